// ===== src/tle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_pkg
// Key codes, result actions and the shift control word shared by the
// terminal line editor modules.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam logic [7:0] KEY_DEL    = 8'd127;
  localparam logic [7:0] KEY_BS     = 8'd8;
  localparam logic [7:0] KEY_CTRL_W = 8'd23;
  localparam logic [7:0] KEY_CTRL_U = 8'd21;
  localparam logic [7:0] KEY_NL     = 8'd10;
  localparam logic [7:0] KEY_CTRL_D = 8'd4;
  localparam logic [7:0] KEY_SPACE  = 8'd32;

  typedef enum logic [1:0] {
    ACT_ECHO    = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_NEWLINE = 2'd2,
    ACT_END     = 2'd3
  } action_t;

  // push moves every character one cell away from the tail, pop one cell towards it
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

// ===== src/tle_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_in_if / tle_out_if
// Valid/ready channels for keyboard bytes and display action words.
// ----------------------------------------------------------------------------
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tle_out_if;
  logic                valid;
  logic                ready;
  tle_pkg::action_t    action;
  logic [7:0]          out_byte;
  logic                last;

  modport source (output valid, output action, output out_byte, output last, input ready);
  modport sink   (input valid, input action, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== src/tle_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_cell
// One character slot of the line stack; takes its neighbour's character on
// a push or a pop.
// ----------------------------------------------------------------------------
module tle_cell (
  input  wire logic           clk,
  input  wire tle_pkg::shift_t ctl,
  input  wire logic [7:0]     prev_data,
  input  wire logic [7:0]     next_data,
  output logic      [7:0]     data_q
);
  import tle_pkg::*;

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= prev_data;
    end else if (ctl.pop) begin
      data_r <= next_data;
    end
  end

  assign data_q = data_r;

endmodule
`default_nettype wire

// ===== src/terminal_line_editor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_line_editor_core
// Canonical-mode line editor: keyboard bytes in, display actions out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one typed byte per word; out_ch carries display action
//   words (action, out_byte, last), last marking the final word caused by
//   one byte. Both channels are valid/ready.
//   The line is held in a row of LINE_MAX cells; cell 0 always holds the
//   most recent character, and characters shift one cell per push or pop.
//   A byte is taken while idle; each result is then written to the output
//   register once it is free, one result for an echo (two when the line is
//   full) and up to LINE_MAX results for a word or line erase. An erase
//   with nothing to erase gives no word. The erase walk removes one
//   character per cycle from the tail cell while the output register is free.
//   A new byte is taken while the final result of the previous one still
//   waits in the output register; when the receiver stalls, the walk halts
//   with the output register full and resumes as words are taken.
//   Reset empties the line and clears the end-of-session flag; after Ctrl-D
//   every byte is taken and dropped until the next reset.
// ----------------------------------------------------------------------------
module terminal_line_editor_core #(
  parameter int LINE_MAX = 40
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tle_in_if.sink    in_ch,
  tle_out_if.source out_ch
);
  import tle_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_BS   = 8'b00000010,
    S_WSPC = 8'b00000100,
    S_WORD = 8'b00001000,
    S_LINE = 8'b00010000,
    S_NL   = 8'b00100000,
    S_END  = 8'b01000000,
    S_CHAR = 8'b10000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             stopped_r, stopped_nxt;
  logic [7:0]       byte_r;

  logic             out_valid_r, out_valid_nxt;
  action_t          action_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             emit;
  action_t          emit_action;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             out_free;
  logic             in_fire;
  shift_t           shift;

  // cell_q[LINE_MAX] is a spare slot feeding the far end on a pop
  logic [7:0]       cell_q [0:LINE_MAX];
  logic             tail_space;
  logic             next_space;
  logic             len_one;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign tail_space = (cell_q[0] == KEY_SPACE);
  assign next_space = (cell_q[1] == KEY_SPACE);
  assign len_one    = (len_r == LEN_W'(1));
  assign cell_q[LINE_MAX] = '0;

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    emit_action = ACT_ERASE;
    emit_byte   = 8'd0;
    emit_last   = 1'b1;
    shift       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && !stopped_r) begin
          case (in_ch.in_byte)
            KEY_DEL, KEY_BS: state_nxt = S_BS;
            KEY_CTRL_W:      state_nxt = S_WSPC;
            KEY_CTRL_U:      state_nxt = S_LINE;
            KEY_NL:          state_nxt = S_NL;
            KEY_CTRL_D:      state_nxt = S_END;
            default:         state_nxt = S_CHAR;
          endcase
        end
      end
      S_BS: begin
        if (len_r == '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          shift.pop = 1'b1;
          len_nxt   = len_r - LEN_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_WSPC: begin
        if (len_r == '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          shift.pop = 1'b1;
          len_nxt   = len_r - LEN_W'(1);
          if (tail_space) begin
            emit_last = len_one;
          end else begin
            // first character of the word itself
            emit_last = len_one || next_space;
            state_nxt = S_WORD;
          end
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WORD: begin
        if (out_free) begin
          emit      = 1'b1;
          shift.pop = 1'b1;
          len_nxt   = len_r - LEN_W'(1);
          emit_last = len_one || next_space;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LINE: begin
        if (len_r == '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          shift.pop = 1'b1;
          len_nxt   = len_r - LEN_W'(1);
          emit_last = len_one;
          if (len_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_action = ACT_NEWLINE;
          len_nxt     = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_action = ACT_END;
          stopped_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_CHAR: begin
        if (out_free) begin
          emit = 1'b1;
          if (len_r >= LEN_W'(LINE_MAX)) begin
            // full line: break it, then echo on the next pass
            emit_action = ACT_NEWLINE;
            emit_last   = 1'b0;
            len_nxt     = '0;
          end else begin
            emit_action = ACT_ECHO;
            emit_byte   = byte_r;
            shift.push  = 1'b1;
            len_nxt     = len_r + LEN_W'(1);
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_ch.in_byte;
    end
    if (emit) begin
      action_r   <= emit_action;
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  // row of character cells, cell 0 at the tail of the line
  for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
    logic [7:0] prev_data;
    if (i == 0) begin : g_head
      assign prev_data = byte_r;
    end else begin : g_body
      assign prev_data = cell_q[i-1];
    end
    tle_cell u_cell (
      .clk       (clk),
      .ctl       (shift),
      .prev_data (prev_data),
      .next_data (cell_q[i+1]),
      .data_q    (cell_q[i])
    );
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.action   = action_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives keyboard bytes into terminal_line_editor_core and checks each
// display word against a line model kept alongside, with random gaps and
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tle_pkg::*;

  localparam int LINE_MAX       = 40;
  localparam int RANDOM_KEYS    = 340;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [1:0] action;
    logic [7:0] ch;
    logic       last;
  } display_word_t;

  class display_scoreboard;
    logic [7:0]    line_chars [LINE_MAX];
    int unsigned   line_len = 0;
    bit            ended = 1'b0;
    display_word_t awaited_words [$];
    int unsigned   errors = 0;

    function void put(logic [1:0] act, logic [7:0] ch);
      display_word_t w;
      w.action = act;
      w.ch     = ch;
      w.last   = 1'b0;
      awaited_words.push_back(w);
    endfunction

    function void erase_tail();
      line_len--;
      put(ACT_ERASE, 8'h00);
    endfunction

    function bit tail_is_space();
      return line_len > 0 && line_chars[line_len - 1] == KEY_SPACE;
    endfunction

    // work out the display words one accepted key causes
    function void note_key(logic [7:0] key);
      int unsigned   first;
      display_word_t w;
      first = awaited_words.size();
      if (ended) return;
      case (key)
        KEY_DEL, KEY_BS: begin
          if (line_len > 0) erase_tail();
        end
        KEY_CTRL_W: begin
          while (tail_is_space()) erase_tail();
          while (line_len > 0 && !tail_is_space()) erase_tail();
        end
        KEY_CTRL_U: begin
          while (line_len > 0) erase_tail();
        end
        KEY_NL: begin
          put(ACT_NEWLINE, 8'h00);
          line_len = 0;
        end
        KEY_CTRL_D: begin
          put(ACT_END, 8'h00);
          ended = 1'b1;
        end
        default: begin
          // full line: break it before storing the new character
          if (line_len >= LINE_MAX) begin
            put(ACT_NEWLINE, 8'h00);
            line_len = 0;
          end
          line_chars[line_len] = key;
          line_len++;
          put(ACT_ECHO, key);
        end
      endcase
      if (awaited_words.size() > first) begin
        w = awaited_words.pop_back();
        w.last = 1'b1;
        awaited_words.push_back(w);
      end
    endfunction

    function void check_word(logic [1:0] act, logic [7:0] ch, logic last);
      display_word_t w;
      if (awaited_words.size() == 0) begin
        $error("unexpected display word: action %0d out_byte %0d last %0b", act, ch, last);
        errors++;
        return;
      end
      w = awaited_words.pop_front();
      if (act !== w.action) begin
        $error("action: expected %0d, got %0d", w.action, act);
        errors++;
      end
      if (ch !== w.ch) begin
        $error("out_byte: expected %0d, got %0d", w.ch, ch);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction

    function void check_drained();
      if (awaited_words.size() != 0) begin
        $error("%0d display words never arrived", awaited_words.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tle_in_if  key_ch ();
  tle_out_if disp_ch ();

  terminal_line_editor_core #(
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (key_ch),
    .out_ch(disp_ch)
  );

  display_scoreboard sb;
  bit                sender_steady   = 1'b0;
  bit                receiver_steady = 1'b0;
  bit                hold_out        = 1'b0;
  int unsigned       keys_sent       = 0;
  int unsigned       idle_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // called and returns at a falling edge; valid stays high when no gap follows
  task automatic send_key(input logic [7:0] key, input bit rush);
    int unsigned gap;
    key_ch.valid   <= 1'b1;
    key_ch.in_byte <= key;
    do @(posedge clk); while (!key_ch.ready);
    sb.note_key(key);
    keys_sent++;
    @(negedge clk);
    gap = (rush || sender_steady) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 15) == 0) sender_steady = !sender_steady;
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    key_ch.valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] ch;
    if ($urandom_range(0, 4) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do ch = 8'($urandom_range(33, 255)); while (ch == KEY_DEL);
    return ch;
  endfunction

  function automatic logic [7:0] noise_key();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == KEY_CTRL_D);
    return ch;
  endfunction

  function automatic logic [7:0] edit_key();
    case ($urandom_range(0, 3))
      0:       return KEY_BS;
      1:       return KEY_DEL;
      2:       return KEY_CTRL_W;
      default: return KEY_CTRL_U;
    endcase
  endfunction

  // type up to a full line of spaceless characters, then overflow it, wipe it or erase its last word
  task automatic fill_line();
    int unsigned n;
    n = LINE_MAX - sb.line_len;
    repeat (n) send_key(word_char(), 1'b0);
    case ($urandom_range(0, 2))
      0:       repeat ($urandom_range(1, 3)) send_key(word_char(), 1'b0);
      1:       send_key(KEY_CTRL_U, 1'b0);
      default: send_key(KEY_CTRL_W, 1'b0);
    endcase
  endtask

  initial begin
    int unsigned stall;
    disp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        stall    = HOLD_CYCLES;
        hold_out = 1'b0;
      end else begin
        stall = receiver_steady ? 0 : $urandom_range(0, 14);
      end
      if ($urandom_range(0, 15) == 0) receiver_steady = !receiver_steady;
      if (stall > 0) begin
        disp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      disp_ch.ready <= 1'b1;
      do @(posedge clk); while (!disp_ch.valid);
      sb.check_word(disp_ch.action, disp_ch.out_byte, disp_ch.last);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((key_ch.valid && key_ch.ready) || (disp_ch.valid && disp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  opening [$];
    int unsigned kind;
    int unsigned n;
    bit          held;
    bit          drained;
    sb             = new;
    held           = 1'b0;
    drained        = 1'b0;
    rst_n          = 1'b0;
    key_ch.valid   = 1'b0;
    key_ch.in_byte = 8'h00;
    // extremes, erases on an empty line, word erase over trailing spaces
    opening = '{8'h00, 8'hFF, KEY_BS, KEY_DEL, KEY_BS, KEY_CTRL_W, KEY_CTRL_U,
                "a", "b", KEY_SPACE, KEY_SPACE, "c", "d", KEY_SPACE, KEY_SPACE,
                KEY_CTRL_W, KEY_CTRL_W, "x", KEY_NL, "y", "z", KEY_CTRL_U,
                KEY_NL, 8'h80, 8'h7E};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_key(opening[i], 1'b0);

    while (keys_sent < opening.size() + RANDOM_KEYS) begin
      if (!held && keys_sent > 120) begin
        // stall the display side and keep typing so the block backs up
        held     = 1'b1;
        hold_out = 1'b1;
        repeat (30) send_key(word_char(), 1'b1);
      end else if (!drained && keys_sent > 260) begin
        drained = 1'b1;
        wait_drained();
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          n = $urandom_range(1, 8);
          repeat (n) send_key(word_char(), 1'b0);
          repeat ($urandom_range(1, 2)) send_key(KEY_SPACE, 1'b0);
        end else if (kind < 65) begin
          send_key(edit_key(), 1'b0);
        end else if (kind < 73) begin
          send_key(KEY_NL, 1'b0);
        end else if (kind < 80) begin
          fill_line();
        end else begin
          send_key(noise_key(), 1'b0);
        end
      end
    end

    // end the session on a non-empty line; everything after it is dropped
    send_key(word_char(), 1'b0);
    send_key(KEY_CTRL_D, 1'b0);
    send_key(KEY_BS, 1'b0);
    send_key(KEY_NL, 1'b0);
    send_key(KEY_CTRL_D, 1'b0);
    send_key("q", 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tle_pkg.sv
src/tle_if.sv
src/tle_cell.sv
src/terminal_line_editor_core.sv
test/tb.sv
